// ----- hdl/mf3_pkg.sv -----
// Shared constants and types of the 3x3 median filter with replicated border.
package mf3_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 11;
  localparam int CFG_ADDR_W    = 2;
  localparam int ROW_W         = 11;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int RESET_DIM     = 512;
  localparam int WIN           = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN-1:0] col_t;
  typedef col_t [WIN-1:0] win_t;
  typedef logic [1:0] phase_t;

  typedef struct packed {
    pix_t   v;
    phase_t phase;
    logic   emit;
    logic   top;
    logic   bot;
    logic   left;
    logic   right;
    logic   last;
  } item_info_t;

endpackage

// ----- hdl/mf3_line_store.sv -----
// One line store: a row of pixels with one write port and one registered read port.
module mf3_line_store #(
  parameter int DEPTH = mf3_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  mf3_pkg::pix_t            wdata,
  output mf3_pkg::pix_t            rdata
);
  import mf3_pkg::*;

  pix_t mem [DEPTH];
  pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/mf3_ctrl.sv -----
// Configuration registers and raster position counters of the median filter.
module mf3_ctrl #(
  parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mf3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mf3_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            accept,
  input  logic                            opcode,
  input  mf3_pkg::pix_t                   pixel,
  output mf3_pkg::item_info_t             info,
  output logic [$clog2(MAX_WIDTH)-1:0]    mem_addr,
  output logic [mf3_pkg::WIN-1:0]         mem_we
);
  import mf3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  function automatic logic [CFG_W-1:0] dim_m1(input logic [CFG_W-1:0] val,
                                              input int unsigned lim);
    logic [CFG_W-1:0] res;
    if (val == '0) begin
      res = '0;
    end else if (32'(val) > lim) begin
      res = CFG_W'(lim - 1);
    end else begin
      res = val - 1'b1;
    end
    return res;
  endfunction

  logic [CFG_W-1:0] w_m1_r, w_m1_nxt, h_m1_r, h_m1_nxt;
  logic [AW-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  phase_t           phase_r, phase_nxt;
  logic             in_frame, in_col_last, out_col_last, out_row_last, restart;

  assign cfg_ready = 1'b1;
  assign mem_addr  = in_col_r;

  always_comb begin
    in_frame     = (in_row_r <= h_m1_r);
    in_col_last  = (CFG_W'(in_col_r) == w_m1_r);
    out_col_last = (CFG_W'(out_col_r) == w_m1_r);
    out_row_last = (out_row_r == h_m1_r);

    info.v     = opcode ? '0 : pixel;
    info.phase = phase_r;
    info.emit  = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    info.top   = (out_row_r == '0);
    info.bot   = out_row_last;
    info.left  = (out_col_r == '0);
    info.right = out_col_last;
    info.last  = out_row_last && out_col_last;

    for (int k = 0; k < WIN; k++) begin
      mem_we[k] = accept && in_frame && (phase_r == phase_t'(k));
    end
  end

  always_comb begin
    w_m1_nxt    = w_m1_r;
    h_m1_nxt    = h_m1_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    phase_nxt   = phase_r;
    restart     = 1'b0;

    if (accept) begin
      if (in_col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
        phase_nxt  = (phase_r == phase_t'(WIN - 1)) ? '0 : phase_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (info.emit) begin
        if (info.last) begin
          restart = 1'b1;
        end else if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end

    if (cfg_valid) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH: begin
          w_m1_nxt = dim_m1(cfg_data, MAX_WIDTH);
          restart  = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          h_m1_nxt = dim_m1(cfg_data, MAX_HEIGHT);
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      phase_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r    <= dim_m1(CFG_W'(RESET_DIM), MAX_WIDTH);
      h_m1_r    <= dim_m1(CFG_W'(RESET_DIM), MAX_HEIGHT);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      phase_r   <= '0;
    end else begin
      w_m1_r    <= w_m1_nxt;
      h_m1_r    <= h_m1_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      phase_r   <= phase_nxt;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (CFG_W'(in_col_r) <= w_m1_r) && (CFG_W'(out_col_r) <= w_m1_r))
    else $error("column counter beyond the image width");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && info.emit && info.last |=>
      (in_col_r == '0) && (in_row_r == '0) && (out_row_r == '0) && (phase_r == '0))
    else $error("frame did not restart after its last result");

endmodule

// ----- hdl/mf3_window.sv -----
// Window stage: builds the 3x3 neighborhood with border replication and sorts its columns.
module mf3_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mf3_pkg::item_info_t info,
  input  mf3_pkg::col_t       rd_data,
  output logic                win_valid,
  input  logic                win_ready,
  output mf3_pkg::win_t       win,
  output logic                win_last
);
  import mf3_pkg::*;

  function automatic col_t fix_col(input col_t c, input logic top, input logic bot);
    col_t res;
    res = c;
    if (top) begin
      res[0] = c[1];
    end
    if (bot) begin
      res[2] = c[1];
    end
    return res;
  endfunction

  function automatic col_t sort3(input col_t c);
    col_t s;
    pix_t t;
    s = c;
    if (s[0] > s[1]) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    if (s[1] > s[2]) begin
      t = s[1]; s[1] = s[2]; s[2] = t;
    end
    if (s[0] > s[1]) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    return s;
  endfunction

  item_info_t s1_info_r;
  logic       s1_valid_r, s1_valid_nxt, s1_fire, accept;
  logic       win_valid_r, win_valid_nxt, win_last_r;
  col_t       p1_r, p2_r, cur, s_cur, s_p1, s_p2;
  win_t       win_r, win_nxt;

  always_comb begin
    s1_fire  = s1_valid_r && (!s1_info_r.emit || !win_valid_r || win_ready);
    in_ready = !s1_valid_r || s1_fire;
    accept   = in_valid && in_ready;

    // Index 0 of a column is the upper row, index 2 the row of the current word.
    case (s1_info_r.phase)
      2'd1: begin
        cur[0] = rd_data[2];
        cur[1] = rd_data[0];
      end
      2'd2: begin
        cur[0] = rd_data[0];
        cur[1] = rd_data[1];
      end
      default: begin
        cur[0] = rd_data[1];
        cur[1] = rd_data[2];
      end
    endcase
    cur[2] = s1_info_r.v;

    s_cur = sort3(fix_col(cur, s1_info_r.top, s1_info_r.bot));
    s_p1  = sort3(fix_col(p1_r, s1_info_r.top, s1_info_r.bot));
    s_p2  = sort3(fix_col(p2_r, s1_info_r.top, s1_info_r.bot));

    win_nxt[0] = s1_info_r.left ? s_p1 : s_p2;
    win_nxt[1] = s_p1;
    win_nxt[2] = s1_info_r.right ? s_p1 : s_cur;

    s1_valid_nxt  = accept || (s1_valid_r && !s1_fire);
    win_valid_nxt = (s1_fire && s1_info_r.emit) || (win_valid_r && !win_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      win_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      win_valid_r <= win_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
    if (s1_fire) begin
      p1_r <= cur;
      p2_r <= p1_r;
    end
    if (s1_fire && s1_info_r.emit) begin
      win_r      <= win_nxt;
      win_last_r <= s1_info_r.last;
    end
  end

  assign win_valid = win_valid_r;
  assign win       = win_r;
  assign win_last  = win_last_r;

  a_emit_to_window: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_info_r.emit |=> win_valid_r)
    else $error("emitting word did not reach the window register");

  a_window_held: assert property (@(posedge clk) disable iff (!rst_n)
    win_valid_r && !win_ready |=> win_valid_r && $stable(win_r))
    else $error("window register changed while stalled");

endmodule

// ----- hdl/mf3_median.sv -----
// Median stage: merges the sorted columns into the median and holds the output word.
module mf3_median (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          win_valid,
  output logic          win_ready,
  input  mf3_pkg::win_t win,
  input  logic          win_last,
  output logic          out_valid,
  input  logic          out_ready,
  output mf3_pkg::pix_t out_pixel,
  output logic          out_last
);
  import mf3_pkg::*;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pix_t lo, mi, hi, med, pix_r;
  logic out_valid_r, out_valid_nxt, last_r, take;

  always_comb begin
    lo  = max2(max2(win[0][0], win[1][0]), win[2][0]);
    mi  = med3(win[0][1], win[1][1], win[2][1]);
    hi  = min2(min2(win[0][2], win[1][2]), win[2][2]);
    med = med3(lo, mi, hi);

    win_ready     = !out_valid_r || out_ready;
    take          = win_valid && win_ready;
    out_valid_nxt = take || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r  <= med;
      last_r <= win_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = pix_r;
  assign out_last  = last_r;

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !win_valid |=> !out_valid_r)
    else $error("output word repeated after it was taken");

endmodule

// ----- hdl/median_filter_3x3_replicate.sv -----
// Top level of the streaming 3x3 median filter with replicated image border.
// The filter takes one word per clock and gives one median per clock once the pipeline is
// full and not stalled; an output stall holds the output register and backs up through the
// window stage, so a new word is taken whenever the window and output stages can move. The
// word completing a neighborhood passes three registered steps (line store read, column
// sort, median merge) to its median. Results lag the input by one row and one pixel:
// after the last pixel of a frame, send image_width+1 flush words (tuser set) to drain the
// last row; the final median of the frame carries tlast, and the next word starts a new
// frame. Three line stores of MAX_WIDTH bytes hold the rows in rotation and need no clearing
// after reset. A write to either register restarts the frame and must be made while idle.
module median_filter_3x3_replicate #(
  parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // pixel_in
  input  logic                           in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // pixel_out
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mf3_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mf3_pkg::CFG_W-1:0]      cfg_data
);
  import mf3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  item_info_t     info;
  logic [AW-1:0]  mem_addr;
  logic [WIN-1:0] mem_we;
  col_t           rd_data;
  win_t           win;
  logic           in_accept, win_valid, win_ready, win_last;

  assign in_accept = in_tvalid && in_tready;

  mf3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .opcode    (in_tuser),
    .pixel     (in_tdata),
    .info      (info),
    .mem_addr  (mem_addr),
    .mem_we    (mem_we)
  );

  for (genvar k = 0; k < WIN; k++) begin : g_line
    mf3_line_store #(
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (mem_we[k]),
      .re    (in_accept),
      .addr  (mem_addr),
      .wdata (info.v),
      .rdata (rd_data[k])
    );
  end

  mf3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .info      (info),
    .rd_data   (rd_data),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_last  (win_last)
  );

  mf3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_last  (win_last),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
